@@ hw/rtl/phi_sorted_bin_with_wrap_padding_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the phi sorted bin
// Shared concurrent assertion forms, one clock and one synchronous reset.
// ----------------------------------------------------------------------------
`ifndef PHI_SORTED_BIN_WITH_WRAP_PADDING_DEFINES_SVH
`define PHI_SORTED_BIN_WITH_WRAP_PADDING_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSB_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PSB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/psb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psb_pkg
// Types and constants shared by the phi sorted bin modules.
// ----------------------------------------------------------------------------
package psb_pkg;

  // store geometry
  localparam int MAX_NODES = 16;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);

  // field widths
  localparam int ANG_W   = 16;
  localparam int EXT_W   = 18;
  localparam int RAD_W   = 16;
  localparam int ID_W    = 16;
  localparam int LAYER_W = 10;
  localparam int SLOT_W  = 4;

  // binary angle scale: HALF_TURN is pi
  localparam int HALF_TURN = 32768;
  localparam int FULL_TURN = 65536;

  localparam logic [ANG_W-1:0] MARGIN_RESET = 16'd1024;

  // one incoming node
  typedef struct packed {
    logic signed [ANG_W-1:0] angle;
    logic [RAD_W-1:0]        radius;
    logic [ID_W-1:0]         node_id;
    logic [LAYER_W-1:0]      layer;
    logic                    last;
  } req_t;

  // one emitted entry
  typedef struct packed {
    logic signed [EXT_W-1:0] ext_angle;
    logic [ID_W-1:0]         out_node_id;
    logic [LAYER_W-1:0]      out_layer;
    logic [SLOT_W-1:0]       slot;
    logic [RAD_W-1:0]        min_radius;
    logic [RAD_W-1:0]        max_radius;
    logic                    overflow;
    logic                    final_res;
  } res_t;

  // one stored node (radius is folded into min/max on arrival)
  typedef struct packed {
    logic signed [ANG_W-1:0] angle;
    logic [ID_W-1:0]         node_id;
    logic [LAYER_W-1:0]      layer;
  } entry_t;

  // node memory write port
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } mem_wr_t;

  // control to output stage
  typedef struct packed {
    logic                    push;
    logic                    flush;
    logic signed [EXT_W-1:0] ext_angle;
    logic [ID_W-1:0]         node_id;
    logic [LAYER_W-1:0]      layer;
    logic [SLOT_W-1:0]       slot;
    logic [RAD_W-1:0]        min_radius;
    logic [RAD_W-1:0]        max_radius;
    logic                    overflow;
  } emit_cmd_t;

endpackage
`default_nettype wire

@@ hw/rtl/psb_node_mem.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psb_node_mem
// Node store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module psb_node_mem (
  input  wire logic                    clk,
  input  wire psb_pkg::mem_wr_t        mem_wr,
  input  wire logic [psb_pkg::IDX_W-1:0] rd_addr,
  output psb_pkg::entry_t              rd_data
);
  import psb_pkg::*;

  entry_t mem [MAX_NODES];

  // write port
  always_ff @(posedge clk) begin
    if (mem_wr.we) begin
      mem[mem_wr.addr] <= mem_wr.data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

@@ hw/rtl/psb_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psb_ctrl
// Insertion sequencer and emission sequencer around the node memory.
// ----------------------------------------------------------------------------
module psb_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire psb_pkg::req_t             req,
  input  wire logic [psb_pkg::ANG_W-1:0] wrap_margin,
  input  wire psb_pkg::entry_t           rd_data,
  output logic                           busy,
  output logic [psb_pkg::IDX_W-1:0]      rd_addr,
  output psb_pkg::mem_wr_t               mem_wr,
  output psb_pkg::emit_cmd_t             cmd
);
  import psb_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOOK  = 5'b00010,
    S_CMP   = 5'b00100,
    S_EMIT  = 5'b01000,
    S_DRAIN = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    PASS_LOW  = 2'd0,
    PASS_MID  = 2'd1,
    PASS_HIGH = 2'd2
  } pass_t;

  state_t           state;
  req_t             item;
  logic [IDX_W-1:0] pos;
  logic [CNT_W-1:0] node_count;
  logic [RAD_W-1:0] radius_low;
  logic [RAD_W-1:0] radius_high;
  logic             overflow_seen;

  // emission: issue stage (address) and evaluate stage (data back)
  logic             iss_on;
  pass_t            iss_pass;
  logic [IDX_W-1:0] iss_idx;
  logic             tag_valid;
  pass_t            tag_pass;
  logic [IDX_W-1:0] tag_idx;

  logic                    full;
  logic [IDX_W-1:0]        last_idx;
  entry_t                  item_entry;
  logic                    moves_up;
  logic                    ins_done;
  logic                    eval_end;
  logic signed [EXT_W-1:0] ang_ext;
  logic signed [EXT_W-1:0] upper_limit;
  logic signed [EXT_W-1:0] lower_limit;

  assign full       = (node_count == CNT_W'(MAX_NODES));
  assign last_idx   = IDX_W'(node_count - 1'b1);
  assign item_entry = '{angle: item.angle, node_id: item.node_id, layer: item.layer};
  assign moves_up   = (rd_data.angle > item.angle);
  assign ang_ext    = {{(EXT_W-ANG_W){rd_data.angle[ANG_W-1]}}, rd_data.angle};

  // wrap limits in 18-bit two's complement
  assign upper_limit = signed'(EXT_W'(HALF_TURN) - EXT_W'(wrap_margin));
  assign lower_limit = signed'(EXT_W'(wrap_margin) - EXT_W'(HALF_TURN));

  assign busy = (state != S_IDLE);

  // memory port and emission datapath
  // Insertion reads slot pos-2 while it writes slot pos, so a read never
  // sees an entry written in the same pass; no forwarding needed.
  always_comb begin
    rd_addr        = iss_idx;
    mem_wr.we      = 1'b0;
    mem_wr.addr    = pos;
    mem_wr.data    = item_entry;
    ins_done       = 1'b0;
    eval_end       = 1'b0;
    cmd.push       = 1'b0;
    cmd.flush      = 1'b0;
    cmd.ext_angle  = ang_ext;
    cmd.node_id    = rd_data.node_id;
    cmd.layer      = rd_data.layer;
    cmd.slot       = SLOT_W'(tag_idx);
    cmd.min_radius = radius_low;
    cmd.max_radius = radius_high;
    cmd.overflow   = overflow_seen;
    unique case (state)
      S_LOOK: begin
        if (pos == '0) begin
          mem_wr.we = 1'b1;
          ins_done  = 1'b1;
        end else begin
          rd_addr = pos - 1'b1;
        end
      end
      S_CMP: begin
        mem_wr.we = 1'b1;
        if (moves_up) begin
          mem_wr.data = rd_data;
          rd_addr     = pos - IDX_W'(2);
        end else begin
          ins_done = 1'b1;
        end
      end
      S_EMIT: begin
        if (tag_valid) begin
          case (tag_pass)
            PASS_LOW: begin
              cmd.push      = (ang_ext > upper_limit);
              cmd.ext_angle = ang_ext - EXT_W'(FULL_TURN);
            end
            PASS_MID: begin
              cmd.push = 1'b1;
            end
            PASS_HIGH: begin
              cmd.push      = (ang_ext < lower_limit);
              cmd.ext_angle = ang_ext + EXT_W'(FULL_TURN);
              eval_end      = !cmd.push || (tag_idx == last_idx);
            end
            default: ;
          endcase
        end
      end
      S_DRAIN: begin
        cmd.flush = 1'b1;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      node_count    <= '0;
      radius_low    <= '1;
      radius_high   <= '0;
      overflow_seen <= 1'b0;
      iss_on        <= 1'b0;
      tag_valid     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            item <= req;
            if (full) begin
              overflow_seen <= 1'b1;
              if (req.last) begin
                state     <= S_EMIT;
                iss_on    <= 1'b1;
                iss_pass  <= PASS_LOW;
                iss_idx   <= '0;
                tag_valid <= 1'b0;
              end
            end else begin
              pos   <= node_count[IDX_W-1:0];
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          if (pos != '0) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (moves_up) begin
            pos <= pos - 1'b1;
            if (pos == IDX_W'(1)) begin
              state <= S_LOOK;
            end
          end
        end
        S_EMIT: begin
          if (eval_end) begin
            state     <= S_DRAIN;
            iss_on    <= 1'b0;
            tag_valid <= 1'b0;
          end else if (iss_on) begin
            tag_valid <= 1'b1;
            tag_pass  <= iss_pass;
            tag_idx   <= iss_idx;
            if (iss_idx == last_idx) begin
              iss_idx <= '0;
              case (iss_pass)
                PASS_LOW:  iss_pass <= PASS_MID;
                PASS_MID:  iss_pass <= PASS_HIGH;
                default:   iss_on   <= 1'b0;
              endcase
            end else begin
              iss_idx <= iss_idx + 1'b1;
            end
          end else begin
            tag_valid <= 1'b0;
          end
        end
        S_DRAIN: begin
          node_count    <= '0;
          radius_low    <= '1;
          radius_high   <= '0;
          overflow_seen <= 1'b0;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      // node placed: count it and fold in its radius
      if (ins_done) begin
        node_count <= node_count + 1'b1;
        if (item.radius < radius_low) begin
          radius_low <= item.radius;
        end
        if (item.radius > radius_high) begin
          radius_high <= item.radius;
        end
        if (item.last) begin
          state     <= S_EMIT;
          iss_on    <= 1'b1;
          iss_pass  <= PASS_LOW;
          iss_idx   <= '0;
          tag_valid <= 1'b0;
        end else begin
          state <= S_IDLE;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/psb_out_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psb_out_stage
// One-entry hold buffer and result register; marks the last entry of a bin.
// ----------------------------------------------------------------------------
module psb_out_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire psb_pkg::emit_cmd_t cmd,
  output logic                    res_valid,
  output psb_pkg::res_t           res
);
  import psb_pkg::*;

  logic                    hold_valid;
  logic signed [EXT_W-1:0] hold_angle;
  logic [ID_W-1:0]         hold_id;
  logic [LAYER_W-1:0]      hold_layer;
  logic [SLOT_W-1:0]       hold_slot;

  // control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      res_valid <= (cmd.push || cmd.flush) && hold_valid;
      if (cmd.push) begin
        hold_valid <= 1'b1;
      end else if (cmd.flush) begin
        hold_valid <= 1'b0;
      end
    end
  end

  // payload: an entry leaves once its successor arrives or the bin ends
  always_ff @(posedge clk) begin
    if (cmd.push || cmd.flush) begin
      res.ext_angle   <= hold_angle;
      res.out_node_id <= hold_id;
      res.out_layer   <= hold_layer;
      res.slot        <= hold_slot;
      res.final_res   <= cmd.flush;
      res.min_radius  <= cmd.flush ? cmd.min_radius : '0;
      res.max_radius  <= cmd.flush ? cmd.max_radius : '0;
      res.overflow    <= cmd.flush && cmd.overflow;
    end
    if (cmd.push) begin
      hold_angle <= cmd.ext_angle;
      hold_id    <= cmd.node_id;
      hold_layer <= cmd.layer;
      hold_slot  <= cmd.slot;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/phi_sorted_bin_with_wrap_padding.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// phi_sorted_bin_with_wrap_padding
// Angle-sorted node bin with wrap-around padded emission.
// ----------------------------------------------------------------------------
// Usage:
//   Requests: drive req and pulse start; a request is taken at an edge with
//   start high and busy low. Nodes are insertion-sorted by angle into a
//   16-entry synchronous node memory, one shifted entry per cycle, and busy
//   stays high while the node is placed. A node arriving at a full store is
//   dropped, flagging overflow. A request with last set starts emission after
//   it is stored or dropped: three passes over the memory (lower wrap copies,
//   all nodes, upper wrap copies), one memory read per cycle; the upper pass
//   stops at the first node without a copy.
//   Results: res_valid marks each result for exactly one cycle; the receiver
//   cannot stall. A result leaves in the cycle after the next one is found, the
//   final one (final_res, radius range, overflow) in the first cycle with
//   busy low again.
//   Config: cfg_we writes cfg_wdata to wrap_margin; write only while idle.
//   Reset: empties the bin, wrap_margin returns to 1024. Memory contents are
//   not cleared; only entries below the node count are ever used.
// ----------------------------------------------------------------------------
`include "phi_sorted_bin_with_wrap_padding_defines.svh"

module phi_sorted_bin_with_wrap_padding (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire psb_pkg::req_t             req,
  output logic                           res_valid,
  output psb_pkg::res_t                  res,
  input  wire logic                      cfg_we,
  input  wire logic [psb_pkg::ANG_W-1:0] cfg_wdata
);
  import psb_pkg::*;

  logic [ANG_W-1:0] wrap_margin;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;
  mem_wr_t          mem_wr;
  emit_cmd_t        cmd;

  // margin register
  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_margin <= MARGIN_RESET;
    end else if (cfg_we) begin
      wrap_margin <= cfg_wdata;
    end
  end

  psb_node_mem u_mem (
    .clk     (clk),
    .mem_wr  (mem_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  psb_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .req         (req),
    .wrap_margin (wrap_margin),
    .rd_data     (rd_data),
    .busy        (busy),
    .rd_addr     (rd_addr),
    .mem_wr      (mem_wr),
    .cmd         (cmd)
  );

  psb_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res       (res)
  );

  // checks
  `PSB_ASSERT_SAME(a_wr_busy, clk, rst, mem_wr.we, busy, "node memory written while idle")
  `PSB_ASSERT_SAME(a_final_idle, clk, rst, res_valid && res.final_res, !busy, "final result while busy")
  `PSB_ASSERT_SAME(a_final_flush, clk, rst, res_valid && res.final_res, $past(cmd.flush), "final result without bin flush")
  `PSB_ASSERT_NEXT(a_flush_empty, clk, rst, cmd.flush, !cmd.push && !busy, "emission continues after flush")

endmodule
`default_nettype wire

@@ test/phi_sorted_bin_with_wrap_padding_tb.sv @@
// ----------------------------------------------------------------------------
// phi_sorted_bin_with_wrap_padding_tb
// Loads bins of nodes through the start/busy request port and predicts the
// sorted, wrap-padded entry list of every bin in a scoreboard that keeps its
// own sorted copy of the bin. Each strobed result is checked field by field
// against the oldest predicted entry. The margin register is rewritten between
// phases, with zero, one, pi, full scale and random values.
// ----------------------------------------------------------------------------
module phi_sorted_bin_with_wrap_padding_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          PHASES      = 6;
  localparam int          PHASE_NODES = 44;

  // Predicts the entry list of each bin and checks the emitted entries.
  class bin_scoreboard;
    entry_t            nodes[$];
    res_t              expected_q[$];
    logic [ANG_W-1:0]  margin;
    logic [RAD_W-1:0]  rad_lo;
    logic [RAD_W-1:0]  rad_hi;
    bit                dropped;
    int                errors;
    int                reported;

    function new();
      margin   = MARGIN_RESET;
      errors   = 0;
      reported = 0;
      clear_bin();
    endfunction

    function void clear_bin();
      nodes.delete();
      rad_lo  = '1;
      rad_hi  = '0;
      dropped = 1'b0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function res_t make_entry(int a, int i);
      res_t e;
      e             = '0;
      e.ext_angle   = EXT_W'(a);
      e.out_node_id = nodes[i].node_id;
      e.out_layer   = nodes[i].layer;
      e.slot        = SLOT_W'(i);
      return e;
    endfunction

    // Insert the node in angle order (ties after older nodes); on last,
    // build lower copies, all nodes, then the leading upper copies.
    function void note(req_t r);
      entry_t n;
      int     pos;
      int     upper;
      int     lower;
      int     a;
      int     i;
      res_t   out_q[$];
      res_t   tail;
      if (nodes.size() < MAX_NODES) begin
        n.angle   = r.angle;
        n.node_id = r.node_id;
        n.layer   = r.layer;
        pos = nodes.size();
        while (pos > 0 && nodes[pos-1].angle > r.angle) pos--;
        nodes.insert(pos, n);
        if (r.radius < rad_lo) rad_lo = r.radius;
        if (r.radius > rad_hi) rad_hi = r.radius;
      end else begin
        dropped = 1'b1;
      end
      if (!r.last) return;
      upper = HALF_TURN - int'(margin);
      lower = int'(margin) - HALF_TURN;
      for (i = 0; i < nodes.size(); i++) begin
        a = nodes[i].angle;
        if (a > upper) out_q = {out_q, make_entry(a - FULL_TURN, i)};
      end
      for (i = 0; i < nodes.size(); i++) begin
        a = nodes[i].angle;
        out_q = {out_q, make_entry(a, i)};
      end
      for (i = 0; i < nodes.size(); i++) begin
        a = nodes[i].angle;
        if (a >= lower) break;
        out_q = {out_q, make_entry(a + FULL_TURN, i)};
      end
      // the closing entry carries the bin summary
      tail = out_q.pop_back();
      tail.min_radius = rad_lo;
      tail.max_radius = rad_hi;
      tail.overflow   = dropped;
      tail.final_res  = 1'b1;
      out_q = {out_q, tail};
      expected_q = {expected_q, out_q};
      clear_bin();
    endfunction

    function void complain(string what, res_t want, res_t got);
      errors++;
      if (reported < 10) begin
        reported++;
        $display("%0t ns: %s", $realtime, what);
        $display("  exp: ang=%0d id=%0d layer=%0d slot=%0d rmin=%0d rmax=%0d ovf=%0b fin=%0b",
                 want.ext_angle, want.out_node_id, want.out_layer, want.slot,
                 want.min_radius, want.max_radius, want.overflow, want.final_res);
        $display("  got: ang=%0d id=%0d layer=%0d slot=%0d rmin=%0d rmax=%0d ovf=%0b fin=%0b",
                 got.ext_angle, got.out_node_id, got.out_layer, got.slot,
                 got.min_radius, got.max_radius, got.overflow, got.final_res);
      end
    endfunction

    function void check(res_t got);
      res_t want;
      bit   bad;
      if (expected_q.size() == 0) begin
        complain("entry emitted with none predicted", '0, got);
        return;
      end
      want = expected_q.pop_front();
      bad  = (got.ext_angle   !== want.ext_angle)   ||
             (got.out_node_id !== want.out_node_id) ||
             (got.out_layer   !== want.out_layer)   ||
             (got.slot        !== want.slot)        ||
             (got.min_radius  !== want.min_radius)  ||
             (got.max_radius  !== want.max_radius)  ||
             (got.overflow    !== want.overflow)    ||
             (got.final_res   !== want.final_res);
      if (bad) complain("entry mismatch", want, got);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             start;
  logic             busy;
  req_t             req;
  logic             res_valid;
  res_t             res;
  logic             cfg_we;
  logic [ANG_W-1:0] cfg_wdata;

  bin_scoreboard sb;
  bit            start_hi;
  int unsigned   cycle_count = 0;

  phi_sorted_bin_with_wrap_padding dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .res_valid (res_valid),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // results cannot be held off: take every strobe
  always @(posedge clk) begin
    if (!rst && res_valid) sb.check(res);
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  function automatic req_t mk(int a, int rad, int id, int lay, bit last);
    req_t r;
    r.angle   = ANG_W'(a);
    r.radius  = RAD_W'(rad);
    r.node_id = ID_W'(id);
    r.layer   = LAYER_W'(lay);
    r.last    = last;
    return r;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // angles cluster at the wrap thresholds and the turn ends; some repeat
  function automatic logic [ANG_W-1:0] pick_angle(logic [ANG_W-1:0] m,
                                                  logic [ANG_W-1:0] prev);
    int upper;
    int lower;
    int a;
    upper = HALF_TURN - int'(m);
    lower = int'(m) - HALF_TURN;
    case ($urandom_range(0, 7))
      0, 1:    a = int'($urandom_range(0, 65535)) - HALF_TURN;
      2:       a = upper + int'($urandom_range(0, 2)) - 1;
      3:       a = lower + int'($urandom_range(0, 2)) - 1;
      4:       a = 32767 - int'($urandom_range(0, 2047));
      5:       a = int'($urandom_range(0, 2047)) - HALF_TURN;
      6:       a = int'(prev);
      default: a = $urandom_range(0, 1) ? 32767 : -32768;
    endcase
    return a[ANG_W-1:0];
  endfunction

  // one request through the start/busy handshake
  task automatic send_node(req_t r, int gap);
    start    <= 1'b1;
    req      <= r;
    start_hi  = 1'b1;
    do @(posedge clk); while (busy);
    sb.note(r);
    if (gap > 0) begin
      start    <= 1'b0;
      start_hi  = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_bin(int n, logic [ANG_W-1:0] m, bit burst);
    req_t             r;
    logic [ANG_W-1:0] prev;
    int               i;
    prev = ANG_W'($urandom_range(0, 65535));
    for (i = 0; i < n; i++) begin
      r.angle   = pick_angle(m, prev);
      r.radius  = RAD_W'($urandom_range(0, 65535));
      r.node_id = ID_W'($urandom_range(0, 65535));
      r.layer   = LAYER_W'($urandom_range(0, 1023));
      r.last    = (i == n - 1);
      prev      = r.angle;
      send_node(r, pick_gap(burst));
    end
  endtask

  // stop sending and let the block drain completely
  task automatic settle();
    if (start_hi) begin
      start    <= 1'b0;
      start_hi  = 1'b0;
      @(posedge clk);
    end
    while (sb.pending() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_margin(logic [ANG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.margin  = v;
  endtask

  initial begin
    logic [ANG_W-1:0] m;
    int               done;
    int               n;
    int               i;
    sb        = new();
    start_hi  = 1'b0;
    rst       = 1'b1;
    start     = 1'b0;
    req       = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // turn ends, field extremes and equal angles, reset margin
    send_node(mk( 32767,     0,     0,    0, 0), 0);
    send_node(mk(-32768, 65535, 65535, 1023, 0), 1);
    send_node(mk(     0,   100,     1,    1, 0), 0);
    send_node(mk(    -1,   200,     2,    2, 0), 2);
    send_node(mk( 32767,   300,     3,    3, 0), 0);
    send_node(mk(-32768,   400,     4,    4, 1), 0);
    // one either side of each wrap threshold
    send_node(mk( 31744,    10,    11,   12, 0), 0);
    send_node(mk(-31744,    20,    21,   22, 0), 0);
    send_node(mk(-31745,    30,    31,   32, 0), 3);
    send_node(mk( 31745,    40,    41,   42, 1), 1);
    // store full: each node lands in front, the last one is dropped
    for (i = 0; i <= MAX_NODES; i++)
      send_node(mk(30000 - i * 3700, $urandom_range(0, 65535), i, i,
                   i == MAX_NODES), i % 2);
    settle();

    // random bins under a range of margins, margin beyond pi included
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       m = 16'd0;
        1:       m = 16'd32768;
        2:       m = 16'hFFFF;
        3:       m = 16'd1;
        4:       m = ANG_W'($urandom_range(0, 32768));
        default: m = ANG_W'($urandom_range(0, 65535));
      endcase
      write_margin(m);
      done = 0;
      while (done < PHASE_NODES) begin
        case ($urandom_range(0, 9))
          0:       n = $urandom_range(MAX_NODES + 1, MAX_NODES + 4);
          1, 2:    n = $urandom_range(1, 3);
          default: n = $urandom_range(4, MAX_NODES);
        endcase
        send_bin(n, m, $urandom_range(0, 3) == 0);
        done += n;
        if ($urandom_range(0, 5) == 0) settle();
      end
      settle();
    end

    repeat (40) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.errors += sb.pending();
      $display("%0d predicted entries never emitted", sb.pending());
    end
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/psb_pkg.sv
hw/rtl/psb_node_mem.sv
hw/rtl/psb_ctrl.sv
hw/rtl/psb_out_stage.sv
hw/rtl/phi_sorted_bin_with_wrap_padding.sv
test/phi_sorted_bin_with_wrap_padding_tb.sv
